// ----- hw/rtl/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg: shared definitions of the positional list engine
// Operation and status codes, field widths and the command/status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int FUNC_W   = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam int S_TDATA_W = 40;  // position, value, zero pad
    localparam int M_TDATA_W = 48;  // data, status, count, zero pad

    typedef enum logic [FUNC_W-1:0] {
        F_INS_HEAD = 3'd0,
        F_INS_TAIL = 3'd1,
        F_INS_AT   = 3'd2,
        F_DEL_HEAD = 3'd3,
        F_DEL_TAIL = 3'd4,
        F_DEL_AT   = 3'd5,
        F_READOUT  = 3'd6
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic apply;      // execute the accepted word and load its single result
        logic read_load;  // start a readout: load the remaining-entries counter
        logic read_step;  // emit the head entry and rotate the list by one
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic read_go;    // accepted word is a readout of a non-empty list
        logic last_word;  // the readout step in progress emits the final entry
    } stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ple_ctrl.sv -----
// ----------------------------------------------------------------------------
// ple_ctrl: sequencer of the positional list engine
// Owns the handshakes and the output valid flag; steps the datapath through
// single-result operations and multi-word readouts.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output ple_pkg::cmd_t       cmd,
    input  wire ple_pkg::stat_t stat
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;
    logic   accept;

    // output slot is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (stat.read_go) begin
                        cmd.read_load = 1'b1;
                        state_next    = S_READ;
                    end else begin
                        cmd.apply = 1'b1;
                    end
                end
            end
            S_READ: begin
                if (out_free) begin
                    cmd.read_step = 1'b1;
                    if (stat.last_word) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_free) begin
            m_tvalid_next = cmd.apply || cmd.read_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ple_datapath.sv -----
// ----------------------------------------------------------------------------
// ple_datapath: shifting cell array and result register
// Decodes the operation, checks range, shifts the cells for insert, delete
// and readout rotation, and holds the outgoing result word.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_datapath #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [ple_pkg::FUNC_W-1:0]     func,
    input  wire logic [ple_pkg::POS_W-1:0]      position,
    input  wire logic signed [ple_pkg::VALUE_W-1:0] value,
    input  wire ple_pkg::cmd_t                  cmd,
    output ple_pkg::stat_t                      stat,
    output logic signed [ple_pkg::VALUE_W-1:0]  out_data,
    output logic [ple_pkg::STATUS_W-1:0]        out_status,
    output logic [ple_pkg::COUNT_W-1:0]         out_count,
    output logic                                out_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;
    localparam int VW = ple_pkg::VALUE_W;

    logic [VW-1:0]  cell_reg [CAPACITY];
    logic [CW-1:0]  count_reg, count_new, count_m1;
    logic [CW-1:0]  remain_reg, remain_next;
    logic [CW-1:0]  idx;
    logic [XW-1:0]  pos_x, cnt_x;
    logic           ins_pos_ok, del_pos_ok, is_full, is_empty;
    logic           op_ins, op_del;
    logic           do_ins, do_del, do_rot;
    ple_pkg::status_t op_status;

    logic signed [VW-1:0]           out_data_reg, out_data_next;
    logic [ple_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [ple_pkg::COUNT_W-1:0]    out_count_reg, out_count_next;
    logic                           out_last_reg, out_last_next;

    assign pos_x      = XW'(position);
    assign cnt_x      = XW'(count_reg);
    assign is_full    = (count_reg == CW'(CAPACITY));
    assign is_empty   = (count_reg == '0);
    assign count_m1   = count_reg - CW'(1);
    assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
    assign del_pos_ok = (pos_x != '0) && (pos_x <= cnt_x);

    // operation decode and range check
    always_comb begin
        op_ins    = 1'b0;
        op_del    = 1'b0;
        idx       = '0;
        op_status = ple_pkg::ST_OK;
        count_new = count_reg;
        unique case (func) inside
            ple_pkg::F_INS_HEAD, ple_pkg::F_INS_TAIL, ple_pkg::F_INS_AT: begin
                if (is_full) begin
                    op_status = ple_pkg::ST_FULL;
                end else if (func == ple_pkg::F_INS_AT && !ins_pos_ok) begin
                    op_status = ple_pkg::ST_INVALID;
                end else begin
                    op_ins    = 1'b1;
                    count_new = count_reg + CW'(1);
                    if (func == ple_pkg::F_INS_TAIL) begin
                        idx = count_reg;
                    end else if (func == ple_pkg::F_INS_AT) begin
                        idx = CW'(pos_x - XW'(1));
                    end
                end
            end
            ple_pkg::F_DEL_HEAD, ple_pkg::F_DEL_TAIL, ple_pkg::F_DEL_AT: begin
                if (is_empty) begin
                    op_status = ple_pkg::ST_EMPTY;
                end else if (func == ple_pkg::F_DEL_AT && !del_pos_ok) begin
                    op_status = ple_pkg::ST_INVALID;
                end else begin
                    op_del    = 1'b1;
                    count_new = count_m1;
                    if (func == ple_pkg::F_DEL_TAIL) begin
                        idx = count_m1;
                    end else if (func == ple_pkg::F_DEL_AT) begin
                        idx = CW'(pos_x - XW'(1));
                    end
                end
            end
            ple_pkg::F_READOUT: begin
                if (is_empty) begin
                    op_status = ple_pkg::ST_EMPTY;
                end
            end
            default: begin
                op_status = ple_pkg::ST_INVALID;
            end
        endcase
    end

    assign stat.read_go   = (func == ple_pkg::F_READOUT) && !is_empty;
    assign stat.last_word = (remain_reg == CW'(1));

    assign do_ins = cmd.apply && op_ins;
    assign do_del = cmd.apply && op_del;
    assign do_rot = cmd.read_step;

    // one cell per entry; each sees only its neighbors and the head
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [CW-1:0] POS = CW'(i);
        logic [VW-1:0] prev_w, succ_w, cell_next;

        if (i == 0) begin : g_first
            assign prev_w = cell_reg[0];
        end else begin : g_prev
            assign prev_w = cell_reg[i-1];
        end
        if (i == CAPACITY - 1) begin : g_end
            assign succ_w = cell_reg[i];
        end else begin : g_succ
            assign succ_w = cell_reg[i+1];
        end

        always_comb begin
            cell_next = cell_reg[i];
            if (do_ins) begin
                if (POS > idx) begin
                    cell_next = prev_w;
                end else if (POS == idx) begin
                    cell_next = value;
                end
            end else if (do_del) begin
                if (POS >= idx) begin
                    cell_next = succ_w;
                end
            end else if (do_rot) begin
                // rotate the occupied part so the next entry reaches the head
                if (POS == count_m1) begin
                    cell_next = cell_reg[0];
                end else if (POS < count_m1) begin
                    cell_next = succ_w;
                end
            end
        end

        always_ff @(posedge aclk) begin
            cell_reg[i] <= cell_next;
        end
    end

    always_comb begin
        remain_next     = remain_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        if (cmd.read_load) begin
            remain_next = count_reg;
        end
        if (cmd.apply) begin
            out_data_next   = '0;
            out_status_next = op_status;
            out_count_next  = ple_pkg::COUNT_W'(count_new);
            out_last_next   = 1'b1;
        end else if (cmd.read_step) begin
            out_data_next   = cell_reg[0];
            out_status_next = ple_pkg::ST_OK;
            out_count_next  = ple_pkg::COUNT_W'(count_reg);
            out_last_next   = stat.last_word;
            remain_next     = remain_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            remain_reg <= '0;
        end else begin
            if (cmd.apply) begin
                count_reg <= count_new;
            end
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list with 1-based positions
// Stream-in operations (insert/delete at head, tail or position, readout),
// stream-out one status word per operation or one word per entry.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per operation; s_tuser carries the opcode, s_tdata
//   the position and the value to insert. m_ channel: result words; m_tlast
//   marks the final word caused by an operation.
//   Insert, delete, empty readout and unused opcodes finish in the accept
//   cycle: the result is registered and visible on the next cycle, and a new
//   word is taken every cycle while the receiver keeps m_tready high.
//   A readout of N entries loads its counter in the accept cycle, then emits
//   one entry per cycle from the head while m_tready stays high; the head
//   cell is read and the occupied cells rotate by one each step, so after N
//   steps the list is back in place. s_tready is low during a readout.
//   Stall: while m_tvalid is high and m_tready low the result word holds,
//   s_tready drops and the readout does not advance.
//   Reset (aresetn low, synchronous): the list empties and no result is
//   pending; cell contents are left as they are and are never read before
//   they are written.
//   A full list refuses inserts with status full; counts are reported
//   modulo 128.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // slave side: operation words
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ple_pkg::S_TDATA_W-1:0]   s_tdata,  // [6:0] position, [38:7] value, [39] zero
    input  wire logic [ple_pkg::FUNC_W-1:0]      s_tuser,  // [2:0] func
    // master side: result words
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ple_pkg::M_TDATA_W-1:0]        m_tdata,  // [31:0] data, [33:32] status,
                                                           // [40:34] count, [47:41] zero
    output logic                                 m_tlast
);

    localparam int PW = ple_pkg::POS_W;
    localparam int VW = ple_pkg::VALUE_W;

    ple_pkg::cmd_t                  cmd;
    ple_pkg::stat_t                 stat;
    logic signed [VW-1:0]           out_data;
    logic [ple_pkg::STATUS_W-1:0]   out_status;
    logic [ple_pkg::COUNT_W-1:0]    out_count;

    ple_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .func       (s_tuser),
        .position   (s_tdata[PW-1:0]),
        .value      (s_tdata[PW+VW-1:PW]),
        .cmd        (cmd),
        .stat       (stat),
        .out_data   (out_data),
        .out_status (out_status),
        .out_count  (out_count),
        .out_last   (m_tlast)
    );

    // pack the result word, lowest field first, zero pad to whole bytes
    assign m_tdata = {7'b0, out_count, out_status, out_data};

endmodule

`default_nettype wire

// ----- sim/tb_positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// tb_positional_list_engine: self-checking bench of the positional list engine
// Drives operation words into the stream input, predicts every result word
// from a shadow copy of the list and checks each accepted result word field
// by field against the oldest prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_positional_list_engine;

    localparam int LIST_DEPTH = ple_pkg::CAPACITY_DEF;
    localparam int FUNC_W     = ple_pkg::FUNC_W;
    localparam int POS_W      = ple_pkg::POS_W;
    localparam int VALUE_W    = ple_pkg::VALUE_W;
    localparam int COUNT_W    = ple_pkg::COUNT_W;
    localparam int S_TDATA_W  = ple_pkg::S_TDATA_W;
    localparam int M_TDATA_W  = ple_pkg::M_TDATA_W;
    // the opcode left free by the package; the block answers it with invalid
    localparam logic [FUNC_W-1:0] F_UNUSED = 3'd7;

    typedef struct {
        logic [VALUE_W-1:0] data;
        ple_pkg::status_t   status;
        logic [COUNT_W-1:0] count;
        logic               last;
    } result_word_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // shadow of the list as the block should hold it
    logic [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
    int                 shadow_count = 0;

    result_word_t expected_words [$];
    result_word_t oldest_word;
    int           error_count = 0;
    bit           quiet_mode  = 1'b0;  // no idling on either side while set

    positional_list_engine #(
        .CAPACITY(LIST_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic result_word_t make_word(input logic [VALUE_W-1:0] data,
                                               input ple_pkg::status_t st, input logic last);
        result_word_t w;
        w.data   = data;
        w.status = st;
        w.count  = COUNT_W'(shadow_count);
        w.last   = last;
        return w;
    endfunction

    // Apply one accepted operation word to the shadow list and queue its results.
    task automatic predict_list_op(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                                   input logic [VALUE_W-1:0] v);
        ple_pkg::status_t st;
        int               idx;
        int               i;
        st = ple_pkg::ST_OK;
        case (f) inside
            ple_pkg::F_INS_HEAD, ple_pkg::F_INS_TAIL, ple_pkg::F_INS_AT: begin
                // full wins over a bad position
                if (shadow_count >= LIST_DEPTH) begin
                    st = ple_pkg::ST_FULL;
                end else if (f == ple_pkg::F_INS_AT && (p < 1 || p > shadow_count + 1)) begin
                    st = ple_pkg::ST_INVALID;
                end else begin
                    if (f == ple_pkg::F_INS_HEAD) idx = 0;
                    else if (f == ple_pkg::F_INS_TAIL) idx = shadow_count;
                    else idx = p - 1;
                    for (i = shadow_count; i > idx; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[idx] = v;
                    shadow_count++;
                end
            end
            ple_pkg::F_DEL_HEAD, ple_pkg::F_DEL_TAIL, ple_pkg::F_DEL_AT: begin
                // empty wins over a bad position
                if (shadow_count == 0) begin
                    st = ple_pkg::ST_EMPTY;
                end else if (f == ple_pkg::F_DEL_AT && (p < 1 || p > shadow_count)) begin
                    st = ple_pkg::ST_INVALID;
                end else begin
                    if (f == ple_pkg::F_DEL_HEAD) idx = 0;
                    else if (f == ple_pkg::F_DEL_TAIL) idx = shadow_count - 1;
                    else idx = p - 1;
                    for (i = idx; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                end
            end
            ple_pkg::F_READOUT: begin
                if (shadow_count == 0) begin
                    expected_words.push_back(make_word('0, ple_pkg::ST_EMPTY, 1'b1));
                end else begin
                    for (i = 0; i < shadow_count; i++)
                        expected_words.push_back(make_word(shadow_entries[i], ple_pkg::ST_OK,
                                                           i + 1 == shadow_count));
                end
            end
            default: st = ple_pkg::ST_INVALID;
        endcase
        if (f != ple_pkg::F_READOUT)
            expected_words.push_back(make_word('0, st, 1'b1));
    endtask

    // Send one operation word after a random gap; return once it is accepted.
    task automatic send_op(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                           input logic [VALUE_W-1:0] v);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {1'b0, v, p};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_list_op(f, p, v);
        // leave tvalid up: the next send either drives a new word or drops it
    endtask

    // Drop tvalid and hold until every predicted result word has arrived.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_insert();
        case ($urandom_range(0, 2))
            0: return ple_pkg::F_INS_HEAD;
            1: return ple_pkg::F_INS_TAIL;
            default: return ple_pkg::F_INS_AT;
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_delete();
        case ($urandom_range(0, 2))
            0: return ple_pkg::F_DEL_HEAD;
            1: return ple_pkg::F_DEL_TAIL;
            default: return ple_pkg::F_DEL_AT;
        endcase
    endfunction

    // Mostly legal positions for the current length, some zero, some anywhere.
    function automatic logic [POS_W-1:0] pick_position(input logic [FUNC_W-1:0] f);
        int top;
        int r;
        top = (f == ple_pkg::F_INS_AT) ? shadow_count + 1 : shadow_count;
        r = $urandom_range(0, 9);
        if (top == 0 || r == 0) return POS_W'($urandom_range(0, 127));
        if (r == 1) return '0;
        return POS_W'($urandom_range(1, top));
    endfunction

    // Take each result word as it is accepted and check it against the oldest
    // prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("result word with nothing expected, tdata %h",
                                          m_tdata));
            end else begin
                oldest_word = expected_words.pop_front();
                if (m_tdata[31:0] !== oldest_word.data)
                    report_mismatch($sformatf("data %h, expected %h",
                                              m_tdata[31:0], oldest_word.data));
                if (m_tdata[33:32] !== oldest_word.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_tdata[33:32], oldest_word.status));
                if (m_tdata[40:34] !== oldest_word.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              m_tdata[40:34], oldest_word.count));
                if (m_tlast !== oldest_word.last)
                    report_mismatch($sformatf("tlast %b, expected %b",
                                              m_tlast, oldest_word.last));
            end
        end
    end

    // Receiver: stall a random number of cycles before each result word.
    initial begin : result_sink
        int stall;
        forever begin
            stall = quiet_mode ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    // Deletes and readout on an empty list, plus the unused opcode.
    task automatic test_empty_list();
        send_op(ple_pkg::F_READOUT, 7'd0, 32'h0);
        send_op(ple_pkg::F_DEL_HEAD, 7'd1, 32'h0);
        send_op(ple_pkg::F_DEL_TAIL, 7'd1, 32'h0);
        send_op(ple_pkg::F_DEL_AT, 7'd0, 32'h0);  // empty is reported before the position
        send_op(F_UNUSED, 7'd127, 32'hffff_ffff);
    endtask

    task automatic test_insert_positions();
        send_op(ple_pkg::F_INS_AT, 7'd0, 32'h1234_5678);   // below range
        send_op(ple_pkg::F_INS_AT, 7'd2, 32'h1234_5678);   // beyond count + 1
        send_op(ple_pkg::F_INS_AT, 7'd1, 32'h8000_0000);
        send_op(ple_pkg::F_INS_HEAD, 7'd0, 32'h7fff_ffff);
        send_op(ple_pkg::F_INS_TAIL, 7'd0, 32'hffff_ffff);
        send_op(ple_pkg::F_INS_AT, 7'd4, 32'h0000_0000);   // append through a position
        send_op(ple_pkg::F_INS_AT, 7'd2, 32'h5a5a_5a5a);   // middle
        send_op(ple_pkg::F_READOUT, 7'd0, 32'h0);
    endtask

    task automatic test_delete_positions();
        send_op(ple_pkg::F_DEL_AT, 7'd0, 32'h0);
        send_op(ple_pkg::F_DEL_AT, 7'd6, 32'h0);           // count + 1
        send_op(ple_pkg::F_DEL_AT, 7'd127, 32'h0);
        send_op(ple_pkg::F_DEL_AT, 7'd5, 32'h0);           // last entry
        send_op(ple_pkg::F_DEL_AT, 7'd2, 32'h0);
        send_op(ple_pkg::F_DEL_HEAD, 7'd0, 32'h0);
        send_op(ple_pkg::F_DEL_TAIL, 7'd0, 32'h0);
        send_op(ple_pkg::F_READOUT, 7'd0, 32'h0);          // single entry left
    endtask

    // Fill to capacity, try every insert on a full list, read all of it back,
    // then empty it again.
    task automatic test_full_list();
        logic [FUNC_W-1:0] f;
        quiet_mode = 1'b1;
        while (shadow_count < LIST_DEPTH) begin
            f = pick_insert();
            send_op(f, POS_W'($urandom_range(1, shadow_count + 1)), pick_value());
        end
        quiet_mode = 1'b0;
        send_op(ple_pkg::F_INS_HEAD, 7'd0, pick_value());
        send_op(ple_pkg::F_INS_TAIL, 7'd0, pick_value());
        send_op(ple_pkg::F_INS_AT, 7'd0, pick_value());    // full is reported before position
        send_op(ple_pkg::F_INS_AT, 7'd65, pick_value());
        send_op(ple_pkg::F_INS_AT, 7'd127, pick_value());
        send_op(ple_pkg::F_READOUT, 7'd0, 32'h0);
        send_op(ple_pkg::F_DEL_AT, 7'd64, 32'h0);
        send_op(ple_pkg::F_DEL_AT, 7'd64, 32'h0);          // now one past the end
        send_op(ple_pkg::F_INS_AT, 7'd64, pick_value());   // back to full via count + 1
        while (shadow_count > 0) begin
            f = pick_delete();
            send_op(f, POS_W'($urandom_range(1, shadow_count)), 32'h0);
        end
        send_op(ple_pkg::F_DEL_HEAD, 7'd0, 32'h0);
    endtask

    // Rounds of mixed operations, each with its own growth bias and idling mode.
    task automatic test_random_mix(input int rounds);
        int                grow_pct;
        int                len;
        int                r;
        logic [FUNC_W-1:0] f;
        repeat (rounds) begin
            grow_pct   = $urandom_range(15, 85);
            len        = $urandom_range(12, 22);
            quiet_mode = ($urandom_range(0, 3) == 0);
            repeat (len) begin
                r = $urandom_range(0, 99);
                if (r < 2) f = F_UNUSED;
                else if (r < 10) f = ple_pkg::F_READOUT;
                else if ($urandom_range(0, 99) < grow_pct) f = pick_insert();
                else f = pick_delete();
                send_op(f, pick_position(f), pick_value());
            end
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_list();
        test_insert_positions();
        test_delete_positions();
        wait_for_results();  // hold the sender until the block has answered all
        test_full_list();
        test_random_mix(6);
        wait_for_results();
        test_random_mix(4);
        wait_for_results();
        repeat (4) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_positional_list_engine: done, clean");
        end else begin
            $display("tb_positional_list_engine: done, errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_positional_list_engine: done, errors");
        $finish;
    end

endmodule
